// ----- sv/mzc_pkg.sv -----
`timescale 1ns / 1ps

package mzc_pkg;

	// Default grid capacity.
	localparam int unsigned MAX_ROWS_DEF = 32;
	localparam int unsigned MAX_COLS_DEF = 32;

	// Register indexes of the configuration port.
	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	// Reset value of both grid dimension registers.
	localparam logic [5:0] GRID_DIM_RESET = 6'd16;

	// Neighbour directions, in the order they are examined.
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_DOWN  = 2'd3;

	typedef enum logic [1:0] {
		ACT_CARVE     = 2'd0,
		ACT_BACKTRACK = 2'd1,
		ACT_DONE      = 2'd2,
		ACT_RESTARTED = 2'd3
	} action_t;

	typedef struct packed {
		logic [15:0] random_value;
		logic        restart;
	} item_t;

	typedef struct packed {
		action_t    action;
		logic [4:0] from_row;
		logic [4:0] from_col;
		logic [4:0] to_row;
		logic [4:0] to_col;
		logic [1:0] carve_dir;
		logic [2:0] open_count;
	} result_t;

	// Dimension actually used: saturated into the range two to the grid capacity.
	function automatic logic [5:0] used_dim(logic [5:0] v, int unsigned maxv);
		logic [5:0] res;
		if (v < 6'd2) begin
			res = 6'd2;
		end else if (32'(v) > maxv) begin
			res = 6'(maxv);
		end else begin
			res = v;
		end
		return res;
	endfunction

	// Remainder by three: base-four digits are summed twice, then a small table.
	function automatic logic [1:0] mod3_16(logic [15:0] v);
		logic [4:0] s1;
		logic [2:0] s2;
		logic [1:0] res;
		s1 = 5'd0;
		for (int i = 0; i < 8; i++) begin
			s1 = s1 + 5'(v[2*i +: 2]);
		end
		s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
		case (s2)
			3'd0, 3'd3, 3'd6: res = 2'd0;
			3'd1, 3'd4, 3'd7: res = 2'd1;
			3'd2, 3'd5:       res = 2'd2;
			default:          res = 2'd0;
		endcase
		return res;
	endfunction

endpackage

// ----- sv/mzc_nbr_unit.sv -----
`timescale 1ns / 1ps

// Neighbour address unit, shared by the four neighbour reads and by the move.
module mzc_nbr_unit #(
	parameter int unsigned MAX_ROWS = mzc_pkg::MAX_ROWS_DEF,
	parameter int unsigned MAX_COLS = mzc_pkg::MAX_COLS_DEF,
	localparam int unsigned RW = $clog2(MAX_ROWS),
	localparam int unsigned CLW = $clog2(MAX_COLS),
	localparam int unsigned CW = $clog2(MAX_ROWS * MAX_COLS)
) (
	input  logic [RW-1:0]  row,
	input  logic [CLW-1:0] col,
	input  logic [1:0]     dir,
	input  logic [5:0]     rows_used,
	input  logic [5:0]     cols_used,
	output logic           ok,
	output logic [RW-1:0]  nrow,
	output logic [CLW-1:0] ncol,
	output logic [CW-1:0]  idx
);

	int unsigned r;
	int unsigned c;
	int unsigned nr;
	int unsigned nc;
	int unsigned rows;
	int unsigned cols;

	always_comb begin
		r    = 32'(row);
		c    = 32'(col);
		rows = 32'(rows_used);
		cols = 32'(cols_used);
		nr   = r;
		nc   = c;
		ok   = 1'b0;
		case (dir)
			mzc_pkg::DIR_UP: begin
				ok = (r > 0) && (r - 1 < rows) && (c < cols);
				nr = r - 1;
			end
			mzc_pkg::DIR_LEFT: begin
				ok = (c > 0) && (c - 1 < cols) && (r < rows);
				nc = c - 1;
			end
			mzc_pkg::DIR_RIGHT: begin
				ok = (c + 1 < cols) && (r < rows);
				nc = c + 1;
			end
			mzc_pkg::DIR_DOWN: begin
				ok = (r + 1 < rows) && (c < cols);
				nr = r + 1;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		nrow = RW'(nr);
		ncol = CLW'(nc);
		idx  = ok ? CW'(32'(nrow) * MAX_COLS + 32'(ncol)) : '0;
	end

endmodule

// ----- sv/mzc_visit_map.sv -----
`timescale 1ns / 1ps

// Visited bit per cell, with a clearing sweep after reset and on request.
module mzc_visit_map #(
	parameter int unsigned CELLS = mzc_pkg::MAX_ROWS_DEF * mzc_pkg::MAX_COLS_DEF,
	localparam int unsigned CW = $clog2(CELLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear_start,
	output logic          busy,
	input  logic          wr_en,
	input  logic [CW-1:0] wr_addr,
	input  logic [CW-1:0] rd_addr,
	output logic          rd_data
);

	logic          mem_q [CELLS];
	logic          busy_q;
	logic [CW-1:0] clr_q;
	logic          rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (clear_start) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == CW'(CELLS - 1)) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clr_q] <= 1'b0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= 1'b1;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign busy    = busy_q;
	assign rd_data = rd_q;

endmodule

// ----- sv/mzc_stack.sv -----
`timescale 1ns / 1ps

// Backtrack stack storage; each entry holds a row and a column.
module mzc_stack #(
	parameter int unsigned CELLS = mzc_pkg::MAX_ROWS_DEF * mzc_pkg::MAX_COLS_DEF,
	parameter int unsigned EW = 10,
	localparam int unsigned CW = $clog2(CELLS)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [CW-1:0] wr_addr,
	input  logic [EW-1:0] wr_data,
	input  logic [CW-1:0] rd_addr,
	output logic [EW-1:0] rd_data
);

	logic [EW-1:0] mem_q [CELLS];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ----- sv/dfs_maze_carver.sv -----
`timescale 1ns / 1ps

// Randomised depth-first maze walker: one walk step per input beat.
// The input channel (item_valid / item_ready / item) carries a random word and a
// restart flag. The output channel (result_valid / result_ready / result) returns
// exactly one beat per input beat, in order: a carve, a backtrack, done, or restarted.
// Configuration (cfg_we / cfg_index / cfg_data) sets the rows and columns in use. The user must
// write it only while the block is idle; the block itself does not enforce this. Values
// outside the range two to the grid capacity saturate. The current cell is marked at
// the accepting edge. A step then reads the visited memory once per direction through
// the shared neighbour unit, one direction after another over the single read port,
// collects the last read, picks among the open neighbours, moves or pushes, and loads
// the output register; a backtrack adds a stack read before the load. The input
// reopens when the result is loaded. A restart beat goes from acceptance straight
// to loading the output register.
// After reset, and after each restart beat, the visited memory is swept clear, one
// cell per clock over all MAX_ROWS * MAX_COLS cells (1024 by default); item_ready
// stays low during the sweep, while configuration writes are still taken.
// If the receiver stalls, a finished beat waits in the output register and the walker
// holds its next result until that register is free; a new input beat can still be
// accepted and worked on meanwhile, up to the point where its own result is held.
module dfs_maze_carver #(
	parameter int unsigned MAX_ROWS = mzc_pkg::MAX_ROWS_DEF,
	parameter int unsigned MAX_COLS = mzc_pkg::MAX_COLS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  mzc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output mzc_pkg::result_t result,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [5:0]       cfg_data
);

	localparam int unsigned CELLS = MAX_ROWS * MAX_COLS;
	localparam int unsigned RW    = $clog2(MAX_ROWS);
	localparam int unsigned CLW   = $clog2(MAX_COLS);
	localparam int unsigned CW    = $clog2(CELLS);
	localparam int unsigned DW    = $clog2(CELLS + 1);

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_READ = 7'b0000010,
		S_TAIL = 7'b0000100,
		S_PICK = 7'b0001000,
		S_MOVE = 7'b0010000,
		S_POP  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [5:0] rows_q;
	logic [5:0] cols_q;
	logic [5:0] rows_used;
	logic [5:0] cols_used;

	// Walk state.
	logic [RW-1:0]  cur_row_q;
	logic [CLW-1:0] cur_col_q;
	logic [DW-1:0]  depth_q;
	logic [DW-1:0]  depth_m1;

	// Working registers of the current step.
	logic [RW-1:0]      from_row_q;
	logic [CLW-1:0]     from_col_q;
	logic [15:0]        rv_q;
	logic [1:0]         k_q;
	logic [3:0]         ok_q;
	logic [3:0]         unv_q;
	logic [1:0]         dir_q;
	logic [2:0]         cnt_q;
	mzc_pkg::action_t   act_q;

	// Output register.
	logic             result_valid_q;
	mzc_pkg::result_t result_q;
	logic             out_free;

	// Shared neighbour unit.
	logic [1:0]     n_dir;
	logic           n_ok;
	logic [RW-1:0]  n_row;
	logic [CLW-1:0] n_col;
	logic [CW-1:0]  n_idx;

	// Memory ports.
	logic          map_busy;
	logic          map_wr_en;
	logic [CW-1:0] map_wr_addr;
	logic          map_rd;
	logic          map_clear;
	logic [CW-1:0] cur_idx;
	logic          stk_wr_en;
	logic [RW+CLW-1:0] stk_rd;

	// Pick logic.
	logic [2:0] pick_cnt;
	logic [1:0] pick_idx;
	logic [1:0] pick_dir;
	logic [2:0] seen;

	// Output field extension.
	logic [31:0] fr_ext;
	logic [31:0] fc_ext;
	logic [31:0] tr_ext;
	logic [31:0] tc_ext;

	logic accept;

	assign accept     = item_valid && item_ready;
	assign item_ready = (state_q == S_IDLE) && !map_busy;
	assign out_free   = !result_valid_q || result_ready;

	assign rows_used = mzc_pkg::used_dim(rows_q, MAX_ROWS);
	assign cols_used = mzc_pkg::used_dim(cols_q, MAX_COLS);

	assign cur_idx  = CW'(32'(cur_row_q) * MAX_COLS + 32'(cur_col_q));
	assign depth_m1 = depth_q - DW'(1);

	// During the move the unit looks at the chosen direction, otherwise at the read slot.
	assign n_dir = (state_q == S_MOVE) ? dir_q : k_q;

	mzc_nbr_unit #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_nbr (
		.row       (cur_row_q),
		.col       (cur_col_q),
		.dir       (n_dir),
		.rows_used (rows_used),
		.cols_used (cols_used),
		.ok        (n_ok),
		.nrow      (n_row),
		.ncol      (n_col),
		.idx       (n_idx)
	);

	// The current cell is marked on acceptance; the chosen cell during the move.
	assign map_clear   = accept && item.restart;
	assign map_wr_en   = (accept && !item.restart) ||
	                     ((state_q == S_MOVE) && (cnt_q != 3'd0));
	assign map_wr_addr = (state_q == S_MOVE) ? n_idx : cur_idx;

	mzc_visit_map #(
		.CELLS (CELLS)
	) u_map (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear_start (map_clear),
		.busy        (map_busy),
		.wr_en       (map_wr_en),
		.wr_addr     (map_wr_addr),
		.rd_addr     (n_idx),
		.rd_data     (map_rd)
	);

	// A push is dropped when the stack is full; that cannot happen in a legal walk.
	assign stk_wr_en = (state_q == S_MOVE) && (cnt_q != 3'd0) && (32'(depth_q) < CELLS);

	mzc_stack #(
		.CELLS (CELLS),
		.EW    (RW + CLW)
	) u_stack (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (depth_q[CW-1:0]),
		.wr_data ({cur_row_q, cur_col_q}),
		.rd_addr (depth_m1[CW-1:0]),
		.rd_data (stk_rd)
	);

	// Count the open neighbours and choose the one at index random_value modulo count.
	always_comb begin
		pick_cnt = 3'd0;
		for (int i = 0; i < 4; i++) begin
			pick_cnt = pick_cnt + 3'(unv_q[i]);
		end
		case (pick_cnt)
			3'd2:    pick_idx = {1'b0, rv_q[0]};
			3'd3:    pick_idx = mzc_pkg::mod3_16(rv_q);
			3'd4:    pick_idx = rv_q[1:0];
			default: pick_idx = 2'd0;
		endcase
		pick_dir = mzc_pkg::DIR_UP;
		seen     = 3'd0;
		for (int i = 0; i < 4; i++) begin
			if (unv_q[i]) begin
				if (seen == 3'(pick_idx)) begin
					pick_dir = 2'(i);
				end
				seen = seen + 3'd1;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= mzc_pkg::GRID_DIM_RESET;
			cols_q <= mzc_pkg::GRID_DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mzc_pkg::REG_GRID_ROWS: rows_q <= cfg_data;
				mzc_pkg::REG_GRID_COLS: cols_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Step sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			k_q       <= 2'd0;
			cur_row_q <= '0;
			cur_col_q <= '0;
			depth_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.restart) begin
							cur_row_q <= '0;
							cur_col_q <= '0;
							depth_q   <= '0;
							state_q   <= S_OUT;
						end else begin
							k_q     <= 2'd0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (k_q == mzc_pkg::DIR_DOWN) begin
						state_q <= S_TAIL;
					end
					k_q <= k_q + 2'd1;
				end
				S_TAIL: begin
					state_q <= S_PICK;
				end
				S_PICK: begin
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					if (cnt_q != 3'd0) begin
						cur_row_q <= n_row;
						cur_col_q <= n_col;
						if (32'(depth_q) < CELLS) begin
							depth_q <= depth_q + DW'(1);
						end
						state_q <= S_OUT;
					end else if (depth_q != '0) begin
						depth_q <= depth_m1;
						state_q <= S_POP;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_POP: begin
					cur_row_q <= stk_rd[RW+CLW-1:CLW];
					cur_col_q <= stk_rd[CLW-1:0];
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-step working registers; no reset is needed as each step loads them.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					from_row_q <= cur_row_q;
					from_col_q <= cur_col_q;
					rv_q       <= item.random_value;
					cnt_q      <= 3'd0;
					dir_q      <= mzc_pkg::DIR_UP;
					act_q      <= mzc_pkg::ACT_RESTARTED;
				end
			end
			S_READ: begin
				ok_q[k_q] <= n_ok;
				if (k_q != 2'd0) begin
					unv_q[2'(k_q - 2'd1)] <= ok_q[2'(k_q - 2'd1)] && !map_rd;
				end
			end
			S_TAIL: begin
				unv_q[3] <= ok_q[3] && !map_rd;
			end
			S_PICK: begin
				cnt_q <= pick_cnt;
				dir_q <= pick_dir;
			end
			S_MOVE: begin
				if (cnt_q != 3'd0) begin
					act_q <= mzc_pkg::ACT_CARVE;
				end else if (depth_q != '0) begin
					act_q <= mzc_pkg::ACT_BACKTRACK;
				end else begin
					act_q <= mzc_pkg::ACT_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	// By the output state the current cell already holds the cell the step ends on.
	assign fr_ext = 32'(from_row_q);
	assign fc_ext = 32'(from_col_q);
	assign tr_ext = 32'(cur_row_q);
	assign tc_ext = 32'(cur_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			result_q.action     <= act_q;
			result_q.from_row   <= fr_ext[4:0];
			result_q.from_col   <= fc_ext[4:0];
			result_q.to_row     <= tr_ext[4:0];
			result_q.to_col     <= tc_ext[4:0];
			result_q.carve_dir  <= dir_q;
			result_q.open_count <= cnt_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// A carve always found at least one open neighbour.
	a_carve_has_open: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.action == mzc_pkg::ACT_CARVE) |-> result.open_count != 3'd0)
		else $error("carve beat reports no open neighbour");

	// Every other outcome reports neither a direction nor open neighbours.
	a_other_no_dir: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.action != mzc_pkg::ACT_CARVE) |->
		(result.open_count == 3'd0) && (result.carve_dir == mzc_pkg::DIR_UP))
		else $error("non-carve beat reports a direction or open neighbours");

	// No walk step starts while the visited memory is being swept.
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		map_busy |-> !item_ready)
		else $error("input beat offered while visited memory is clearing");

	// A new result beat is loaded only from the output state.
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_OUT))
		else $error("result beat appeared outside the output state");
`endif

endmodule
